FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation and status codes shared by the rational arithmetic unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_EQUAL  = 3'd4,
      OP_LESS   = 3'd5,
      OP_TO_INT = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   localparam int unsigned MAG_BITS  = 32;
   localparam int unsigned WIDE_BITS = 64;

endpackage

`default_nettype wire

FILE: rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Shared unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
   input  wire logic                                clock,
   input  wire logic [rau_pkg::MAG_BITS-1:0]        mul_a,
   input  wire logic [rau_pkg::MAG_BITS-1:0]        mul_b,
   output logic      [rau_pkg::WIDE_BITS-1:0]       mul_prod
);

   logic [rau_pkg::WIDE_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= rau_pkg::WIDE_BITS'(mul_a) * rau_pkg::WIDE_BITS'(mul_b);
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

FILE: rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit gcd engine
// Binary gcd over 64-bit magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                gcd_start,
   input  wire logic [rau_pkg::WIDE_BITS-1:0]       gcd_x,
   input  wire logic [rau_pkg::WIDE_BITS-1:0]       gcd_y,
   output logic                                     gcd_done,
   output logic      [rau_pkg::WIDE_BITS-1:0]       gcd_result
);

   logic [rau_pkg::WIDE_BITS-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [5:0]                    k_ff, k_in;
   logic                          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (gcd_start) begin
         x_in    = gcd_x;
         y_in    = gcd_y;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         priority if (x_ff == '0) begin
            g_in    = y_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (y_ff == '0) begin
            g_in    = x_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 6'd1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign gcd_done   = done_ff;
   assign gcd_result = g_ff;

endmodule

`default_nettype wire

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                div_start,
   input  wire logic [rau_pkg::WIDE_BITS-1:0]       div_dividend,
   input  wire logic [rau_pkg::WIDE_BITS-1:0]       div_divisor,
   output logic                                     div_done,
   output logic      [rau_pkg::WIDE_BITS-1:0]       div_quotient
);

   logic [rau_pkg::WIDE_BITS:0]   rem_ff, rem_in, rem_sh;
   logic [rau_pkg::WIDE_BITS-1:0] quo_ff, quo_in, dsr_ff, dsr_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[rau_pkg::WIDE_BITS-1:0], quo_ff[rau_pkg::WIDE_BITS-1]};
      if (div_start) begin
         rem_in  = '0;
         quo_in  = div_dividend;
         dsr_in  = div_divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh - {1'b0, dsr_ff};
            quo_in = {quo_ff[rau_pkg::WIDE_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[rau_pkg::WIDE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides and compares two signed fractions,
// reduces results by their gcd, or truncates a fraction to an integer.
//
// req_ carries one transaction: an operation and two fractions. rsp_ returns
// exactly one transaction for each: numerator, denominator (positive for a
// fraction or integer result, else zero), truth bit and status. Both
// channels move a transaction when valid is high and stall is low.
// The time from acceptance to rsp_valid depends on the operation: zero
// denominator and unknown code go straight to the output stage; equal and
// less pass the multiplier states; to integer takes one divider pass; the
// fraction operations are set by the binary gcd loop and two divider passes.
// One transaction is in work at a time: req_stall is high from acceptance
// until the result reaches the output register. A finished result waits in
// the output register while rsp_stall is high; a new request is taken
// meanwhile, and its result is held back until the register is free. Reset
// clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_res_num,
   output logic [30:0]             rsp_res_den,
   output logic                    rsp_truth,
   output logic [1:0]              rsp_status
);

   localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_COMBINE, S_GCD_GO, S_GCD_WAIT,
      S_DIVN_GO, S_DIVN_WAIT, S_DIVD_GO, S_DIVD_WAIT, S_TOINT_GO, S_TOINT_WAIT,
      S_CHECK, S_FINISH
   } state_type;

   state_type           state_ff;
   rau_pkg::op_type     op_ff;
   logic                an_neg_ff, bn_neg_ff, num_neg_ff, den_neg_ff;
   logic [31:0]         an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic [63:0]         p_ff, q_ff, num_mag_ff, den_mag_ff, g_ff, n_ff;
   logic signed [31:0]  out_num_ff, rsp_num_ff;
   logic [30:0]         out_den_ff, rsp_den_ff;
   logic                out_truth_ff, rsp_truth_ff, rsp_valid_ff;
   rau_pkg::status_type out_status_ff, rsp_status_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_prod, div_dividend, div_divisor, div_quotient, gcd_result;
   logic        div_start, div_done, gcd_start, gcd_done;

   rau_pkg::op_type  req_op;
   logic             zero_den, sum_neg, res_neg, ovf;
   logic [63:0]      sum_mag;
   logic signed [63:0] lhs, rhs;

   assign req_op = rau_pkg::op_type'(req_operation);

   always_comb begin
      mul_a = an_mag_ff;
      mul_b = bd_mag_ff;
      unique case (state_ff)
         S_MUL0: begin
            mul_a = an_mag_ff;
            mul_b = (op_ff == rau_pkg::OP_MUL) ? bn_mag_ff : bd_mag_ff;
         end
         S_MUL1: begin
            mul_a = bn_mag_ff;
            mul_b = ad_mag_ff;
         end
         S_MUL2: begin
            mul_a = ad_mag_ff;
            mul_b = (op_ff == rau_pkg::OP_DIV) ? bn_mag_ff : bd_mag_ff;
         end
         default: begin
            mul_a = an_mag_ff;
            mul_b = bd_mag_ff;
         end
      endcase
   end

   assign gcd_start = (state_ff == S_GCD_GO);
   assign div_start = (state_ff == S_DIVN_GO) || (state_ff == S_DIVD_GO) ||
                      (state_ff == S_TOINT_GO);

   always_comb begin
      div_dividend = num_mag_ff;
      div_divisor  = g_ff;
      unique case (state_ff)
         S_DIVD_GO: begin
            div_dividend = den_mag_ff;
            div_divisor  = g_ff;
         end
         S_TOINT_GO: begin
            div_dividend = {32'd0, an_mag_ff};
            div_divisor  = {32'd0, ad_mag_ff};
         end
         default: begin
            div_dividend = num_mag_ff;
            div_divisor  = g_ff;
         end
      endcase
   end

   rau_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   rau_gcd u_gcd (
      .clock      (clock),
      .reset      (reset),
      .gcd_start  (gcd_start),
      .gcd_x      (num_mag_ff),
      .gcd_y      (den_mag_ff),
      .gcd_done   (gcd_done),
      .gcd_result (gcd_result)
   );

   rau_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_comb begin
      zero_den = (req_a_den == '0) ||
                 ((req_op != rau_pkg::OP_TO_INT) && (req_b_den == '0)) ||
                 ((req_op == rau_pkg::OP_DIV) && (req_b_num == '0));
      if (an_neg_ff == (bn_neg_ff ^ (op_ff == rau_pkg::OP_SUB))) begin
         sum_mag = p_ff + q_ff;
         sum_neg = an_neg_ff;
      end else if (p_ff >= q_ff) begin
         sum_mag = p_ff - q_ff;
         sum_neg = an_neg_ff;
      end else begin
         sum_mag = q_ff - p_ff;
         sum_neg = bn_neg_ff ^ (op_ff == rau_pkg::OP_SUB);
      end
      lhs = an_neg_ff ? -$signed(p_ff) : $signed(p_ff);
      rhs = bn_neg_ff ? -$signed(q_ff) : $signed(q_ff);
      if (op_ff == rau_pkg::OP_TO_INT) begin
         res_neg = an_neg_ff && (div_quotient != '0);
         ovf     = res_neg ? (div_quotient > LIM) : (div_quotient >= LIM);
      end else begin
         res_neg = (num_neg_ff != den_neg_ff) && (n_ff != '0);
         ovf     = (div_quotient >= LIM) ||
                   (res_neg ? (n_ff > LIM) : (n_ff >= LIM));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_op;
                  an_neg_ff <= req_a_num[31] ^ req_a_den[31];
                  bn_neg_ff <= req_b_num[31] ^ req_b_den[31];
                  an_mag_ff <= req_a_num[31] ? -req_a_num : req_a_num;
                  ad_mag_ff <= req_a_den[31] ? -req_a_den : req_a_den;
                  bn_mag_ff <= req_b_num[31] ? -req_b_num : req_b_num;
                  bd_mag_ff <= req_b_den[31] ? -req_b_den : req_b_den;
                  out_num_ff    <= '0;
                  out_den_ff    <= '0;
                  out_truth_ff  <= 1'b0;
                  out_status_ff <= rau_pkg::STATUS_OK;
                  if (req_op == rau_pkg::OP_NONE) begin
                     state_ff <= S_FINISH;
                  end else if (zero_den) begin
                     out_status_ff <= rau_pkg::STATUS_ZERO_DEN;
                     state_ff      <= S_FINISH;
                  end else if (req_op == rau_pkg::OP_TO_INT) begin
                     state_ff <= S_TOINT_GO;
                  end else begin
                     state_ff <= S_MUL0;
                  end
               end
            end
            S_MUL0: state_ff <= S_MUL1;
            S_MUL1: begin
               p_ff     <= mul_prod;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               q_ff     <= mul_prod;
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               den_mag_ff <= mul_prod;
               state_ff   <= S_COMBINE;
            end
            S_COMBINE: begin
               den_neg_ff <= 1'b0;
               state_ff   <= S_GCD_GO;
               unique case (op_ff)
                  rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                     num_mag_ff <= sum_mag;
                     num_neg_ff <= sum_neg;
                  end
                  rau_pkg::OP_MUL: begin
                     num_mag_ff <= p_ff;
                     num_neg_ff <= an_neg_ff ^ bn_neg_ff;
                  end
                  rau_pkg::OP_DIV: begin
                     num_mag_ff <= p_ff;
                     num_neg_ff <= an_neg_ff;
                     den_neg_ff <= bn_neg_ff;
                  end
                  default: begin
                     out_truth_ff <= (op_ff == rau_pkg::OP_EQUAL) ? (lhs == rhs)
                                                                  : (lhs < rhs);
                     state_ff     <= S_FINISH;
                  end
               endcase
            end
            S_GCD_GO: state_ff <= S_GCD_WAIT;
            S_GCD_WAIT: begin
               if (gcd_done) begin
                  g_ff     <= gcd_result;
                  state_ff <= S_DIVN_GO;
               end
            end
            S_DIVN_GO: state_ff <= S_DIVN_WAIT;
            S_DIVN_WAIT: begin
               if (div_done) begin
                  n_ff     <= div_quotient;
                  state_ff <= S_DIVD_GO;
               end
            end
            S_DIVD_GO: state_ff <= S_DIVD_WAIT;
            S_DIVD_WAIT: begin
               if (div_done) begin
                  state_ff <= S_CHECK;
               end
            end
            S_TOINT_GO: state_ff <= S_TOINT_WAIT;
            S_TOINT_WAIT: begin
               if (div_done) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= S_FINISH;
               if (ovf) begin
                  out_status_ff <= rau_pkg::STATUS_OVERFLOW;
               end else if (op_ff == rau_pkg::OP_TO_INT) begin
                  out_num_ff <= res_neg ? -div_quotient[31:0] : div_quotient[31:0];
                  out_den_ff <= 31'd1;
               end else begin
                  out_num_ff <= res_neg ? -n_ff[31:0] : n_ff[31:0];
                  out_den_ff <= div_quotient[30:0];
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_num_ff    <= out_num_ff;
                  rsp_den_ff    <= out_den_ff;
                  rsp_truth_ff  <= out_truth_ff;
                  rsp_status_ff <= out_status_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_truth   = rsp_truth_ff;
   assign rsp_status  = rsp_status_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but unit not busy");

   a_error_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rau_pkg::STATUS_OK) |->
         (rsp_res_num == '0) && (rsp_res_den == '0) && !rsp_truth)
      else $error("error response with nonzero fields");

   a_truth_without_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truth |-> (rsp_res_den == '0))
      else $error("comparison response with a denominator");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && rsp_valid_ff && rsp_stall |=> (state_ff == S_FINISH))
      else $error("result left finish while output register busy");

endmodule

`default_nettype wire

FILE: dv/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both channels of the unit. Every accepted request is turned into an
// expected result by an exact sign-magnitude fraction calculator; every
// accepted response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_checker #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [31:0] rsp_res_num,
   input  wire logic [30:0]        rsp_res_den,
   input  wire logic               rsp_truth,
   input  wire logic [1:0]         rsp_status,
   output int                      errors,
   output int                      pending,
   output int                      results_seen
);

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        truth;
      logic [1:0]  status;
   } fraction_result;

   fraction_result expected_results[$];

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_result reduce_fraction(logic signed [65:0] num,
                                                      logic signed [65:0] den);
      fraction_result r;
      logic [63:0] nmag, dmag, g, n, d, lim;
      logic        neg;
      r = '0;
      lim = 64'd1 << (WIDTH - 1);
      nmag = num < 0 ? 64'(-num) : 64'(num);
      dmag = den < 0 ? 64'(-den) : 64'(den);
      if (dmag == 0) begin
         r.status = rau_pkg::STATUS_ZERO_DEN;
         return r;
      end
      g = gcd64(nmag, dmag);
      n = nmag / g;
      d = dmag / g;
      neg = ((num < 0) != (den < 0)) && n != 0;
      if (d >= lim || (neg ? n > lim : n >= lim)) begin
         r.status = rau_pkg::STATUS_OVERFLOW;
         return r;
      end
      r.num = neg ? 32'(-n) : 32'(n);
      r.den = 31'(d);
      r.status = rau_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic fraction_result compute_fraction(rau_pkg::op_type op,
         logic signed [31:0] a_n, logic signed [31:0] a_d,
         logic signed [31:0] b_n, logic signed [31:0] b_d);
      fraction_result r;
      logic signed [65:0] an, ad, bn, bd, l, rt, q;
      logic [63:0] m, lim;
      r = '0;
      if (op == rau_pkg::OP_NONE)
         return r;
      if (a_d == 0 || (op != rau_pkg::OP_TO_INT && b_d == 0) ||
          (op == rau_pkg::OP_DIV && b_n == 0)) begin
         r.status = rau_pkg::STATUS_ZERO_DEN;
         return r;
      end
      an = a_n; ad = a_d; bn = b_n; bd = b_d;
      if (ad < 0) begin
         ad = -ad; an = -an;
      end
      if (bd < 0) begin
         bd = -bd; bn = -bn;
      end
      case (op)
         rau_pkg::OP_ADD:  r = reduce_fraction(an * bd + bn * ad, ad * bd);
         rau_pkg::OP_SUB:  r = reduce_fraction(an * bd - bn * ad, ad * bd);
         rau_pkg::OP_MUL:  r = reduce_fraction(an * bn, ad * bd);
         rau_pkg::OP_DIV:  r = reduce_fraction(an * bd, ad * bn);
         rau_pkg::OP_EQUAL, rau_pkg::OP_LESS: begin
            l = an * bd;
            rt = bn * ad;
            r.truth = (op == rau_pkg::OP_EQUAL) ? (l == rt) : (l < rt);
            r.status = rau_pkg::STATUS_OK;
         end
         default: begin
            lim = 64'd1 << (WIDTH - 1);
            q = an / ad;
            m = q < 0 ? 64'(-q) : 64'(q);
            if (q < 0 ? m > lim : m >= lim) begin
               r.status = rau_pkg::STATUS_OVERFLOW;
            end else begin
               r.num = 32'(q);
               r.den = 31'd1;
               r.status = rau_pkg::STATUS_OK;
            end
         end
      endcase
      return r;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      fraction_result exp_r;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_results.push_back(compute_fraction(
               rau_pkg::op_type'(req_operation),
               req_a_num, req_a_den, req_b_num, req_b_den));
         if (rsp_valid && !rsp_stall) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("%0t: unexpected response num=%0d den=%0d truth=%0b status=%0d",
                           $realtime, rsp_res_num, rsp_res_den, rsp_truth, rsp_status);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_res_num !== exp_r.num || rsp_res_den !== exp_r.den ||
                   rsp_truth !== exp_r.truth || rsp_status !== exp_r.status) begin
                  errors = errors + 1;
                  if (errors <= 10)
                     $display({"%0t: mismatch exp num=%0d den=%0d truth=%0b status=%0d,",
                               " got num=%0d den=%0d truth=%0b status=%0d"},
                              $realtime, $signed(exp_r.num), exp_r.den, exp_r.truth,
                              exp_r.status, rsp_res_num, rsp_res_den, rsp_truth,
                              rsp_status);
               end
            end
         end
         pending = expected_results.size();
      end
   end

endmodule

`default_nettype wire

FILE: dv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction operations under changing request gaps
// and response back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = rau_pkg::OP_ADD;
   logic signed [31:0] req_a_num = '0;
   logic signed [31:0] req_a_den = '0;
   logic signed [31:0] req_b_num = '0;
   logic signed [31:0] req_b_den = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic               rsp_truth;
   logic [1:0]         rsp_status;

   int errors, pending, results_seen;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int sent = 0;

   localparam logic signed [31:0] MAX_S = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_S = 32'sh80000000;

   always #2 clock = ~clock;

   rational_arithmetic_unit uut (.*);

   rational_arithmetic_unit_checker checker_i (.*);

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_transaction(rau_pkg::op_type op, logic signed [31:0] an,
                                   logic signed [31:0] ad,
                                   logic signed [31:0] bn, logic signed [31:0] bd);
      logic stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      forever begin
         #1 stalled = req_stall;
         @(posedge clock);
         if (!stalled)
            break;
         @(negedge clock);
      end
      sent++;
   endtask

   function automatic logic signed [31:0] random_value(bit as_den);
      logic signed [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: v = 0;
               1: v = 1;
               2: v = -1;
               3: v = MAX_S;
               default: v = MIN_S;
            endcase
         end
         1, 2, 3, 4, 5: v = $signed($urandom_range(2000)) - 1000;
         6, 7: v = $urandom;
         default: v = $signed($urandom_range(131070)) - 65535;
      endcase
      if (as_den && v == 0 && $urandom_range(29) != 0)
         v = 1;
      return v;
   endfunction

   task automatic random_phase(int count);
      rau_pkg::op_type op;
      repeat (count) begin
         op = ($urandom_range(49) == 0) ? rau_pkg::OP_NONE
                                        : rau_pkg::op_type'(3'($urandom_range(6)));
         send_transaction(op, random_value(0), random_value(1), random_value(0),
                          random_value(1));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      #6000000;
      $display("rational_arithmetic_unit_tb: errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 66;
      send_transaction(rau_pkg::OP_ADD, 1, 2, 1, 3);
      send_transaction(rau_pkg::OP_SUB, 1, 2, 1, 3);
      send_transaction(rau_pkg::OP_MUL, -2, 3, 3, -4);
      send_transaction(rau_pkg::OP_DIV, 3, 4, -9, 8);
      send_transaction(rau_pkg::OP_EQUAL, 2, 4, -1, -2);
      send_transaction(rau_pkg::OP_LESS, -1, 2, 1, -3);
      send_transaction(rau_pkg::OP_TO_INT, -7, 2, 0, 0);
      send_transaction(rau_pkg::OP_ADD, 1, 0, 1, 3);
      send_transaction(rau_pkg::OP_MUL, 1, 2, 1, 0);
      send_transaction(rau_pkg::OP_DIV, 1, 2, 0, 5);
      send_transaction(rau_pkg::OP_EQUAL, 1, 0, 1, 1);
      send_transaction(rau_pkg::OP_TO_INT, 5, 0, 1, 1);
      send_transaction(rau_pkg::OP_SUB, 3, 7, 3, 7);
      send_transaction(rau_pkg::OP_ADD, MAX_S, 1, MAX_S, 1);
      send_transaction(rau_pkg::OP_TO_INT, MIN_S, -1, 0, 0);
      send_transaction(rau_pkg::OP_TO_INT, MIN_S, 1, 0, 0);
      send_transaction(rau_pkg::OP_MUL, MIN_S, MIN_S, MIN_S, MIN_S);
      send_transaction(rau_pkg::OP_SUB, MIN_S, 1, MAX_S, MIN_S);
      send_transaction(rau_pkg::OP_DIV, MAX_S, MIN_S, MIN_S, MAX_S);
      send_transaction(rau_pkg::OP_LESS, MIN_S, MAX_S, MAX_S, MIN_S);
      send_transaction(rau_pkg::OP_NONE, 5, 5, 5, 5);
      send_transaction(rau_pkg::OP_MUL, -1, 1, MIN_S, 1);
      drain();

      random_phase(250);
      hold_cycles = 1500;
      repeat (4) send_transaction(rau_pkg::OP_ADD, random_value(0), random_value(1),
                                  random_value(0), random_value(1));
      drain();

      send_idle_pct = 66;
      recv_idle_pct = 8;
      random_phase(250);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(250);
      drain();

      $display("Sent %0d transactions (directed edge cases, random operands, all op codes);",
               sent);
      $display("checked %0d responses under varying and long back-pressure.", results_seen);
      if (errors == 0)
         $display("rational_arithmetic_unit_tb: clean");
      else
         $display("rational_arithmetic_unit_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
